// ===== src/gbbc_pkg.sv =====
// Shared types and constants for the glyph bitmap box crop block.
package gbbc_pkg;

   localparam int WORD_W      = 16;
   localparam int DIM_W       = 6;
   localparam int NCOL_W      = 7;
   localparam int NW_W        = 3;
   localparam int ORG_W       = 10;
   localparam int NORG_W      = 11;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int RSP_TDATA_W = 56;

   // Register indexes of the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_ROWS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_COLS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_ROW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_COL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_ALL  = 3'd4;

   // One loaded glyph, with the box already clamped to the store.
   typedef struct packed {
      logic [DIM_W-1:0] nrows;
      logic [DIM_W-1:0] ncols;
      logic [NW_W-1:0]  nwords;
      logic             check_all;
      logic [ORG_W-1:0] origin_row;
      logic [ORG_W-1:0] origin_col;
   } job_type;

endpackage

// ===== src/gbbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbbc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/gbbc_job_fifo.sv =====
// Short queue of loaded glyph jobs between the load side and the crop side.
module gbbc_job_fifo
   import gbbc_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("job queue count above its depth");

endmodule

// ===== src/gbbc_front.sv =====
// Load side: configuration registers, word loading into the store, job hand-off.
module gbbc_front
   import gbbc_pkg::*;
#(
   parameter int MAX_ROWS      = 32,
   parameter int MAX_WORD_COLS = 2,
   localparam int DEPTH  = MAX_ROWS * MAX_WORD_COLS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [WORD_W-1:0]     req_tdata,
   input  logic                  req_tlast,
   output logic                  wr_en,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [WORD_W-1:0]     wr_data,
   output logic                  job_valid,
   input  logic                  job_ready,
   output job_type               job,
   input  logic                  release_hold
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DIM_W-1:0]  box_rows_ff, box_rows_in;
   logic [DIM_W-1:0]  box_cols_ff, box_cols_in;
   logic [ORG_W-1:0]  origin_row_ff, origin_row_in;
   logic [ORG_W-1:0]  origin_col_ff, origin_col_in;
   logic              check_all_ff, check_all_in;
   logic [CNT_W-1:0]  load_count_ff, load_count_in;
   logic              hold_ff, hold_in;
   logic              accept;
   logic              csr_write;
   logic [NCOL_W-1:0] ncols_ext;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   // A new glyph may load only once the previous one has left the store.
   assign req_tready = !hold_ff && job_ready;
   assign accept     = req_tvalid && req_tready;

   assign wr_en   = accept && (load_count_ff < CNT_W'(DEPTH));
   assign wr_addr = load_count_ff[ADDR_W-1:0];
   assign wr_data = req_tdata;

   assign job_valid = accept && req_tlast;

   always_comb begin
      job.nrows = (32'(box_rows_ff) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : box_rows_ff;
      job.ncols = (32'(box_cols_ff) > 16 * MAX_WORD_COLS) ?
                  DIM_W'(16 * MAX_WORD_COLS) : box_cols_ff;
      ncols_ext      = NCOL_W'(job.ncols) + NCOL_W'(15);
      job.nwords     = NW_W'(ncols_ext >> 4);
      job.check_all  = check_all_ff;
      job.origin_row = origin_row_ff;
      job.origin_col = origin_col_ff;
   end

   always_comb begin
      box_rows_in   = box_rows_ff;
      box_cols_in   = box_cols_ff;
      origin_row_in = origin_row_ff;
      origin_col_in = origin_col_ff;
      check_all_in  = check_all_ff;
      load_count_in = load_count_ff;
      hold_in       = hold_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BOX_ROWS:   box_rows_in   = csr_data[DIM_W-1:0];
            CSR_BOX_COLS:   box_cols_in   = csr_data[DIM_W-1:0];
            CSR_ORIGIN_ROW: origin_row_in = csr_data[ORG_W-1:0];
            CSR_ORIGIN_COL: origin_col_in = csr_data[ORG_W-1:0];
            CSR_CHECK_ALL:  check_all_in  = csr_data[0];
            default: ;
         endcase
      end
      if (accept) begin
         if (req_tlast) begin
            load_count_in = '0;
            hold_in       = 1'b1;
         end else if (wr_en) begin
            load_count_in = load_count_ff + 1'b1;
         end
      end
      if (release_hold) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_rows_ff   <= '0;
         box_cols_ff   <= '0;
         origin_row_ff <= '0;
         origin_col_ff <= '0;
         check_all_ff  <= 1'b1;
         load_count_ff <= '0;
         hold_ff       <= 1'b0;
      end else begin
         box_rows_ff   <= box_rows_in;
         box_cols_ff   <= box_cols_in;
         origin_row_ff <= origin_row_in;
         origin_col_ff <= origin_col_in;
         check_all_ff  <= check_all_in;
         load_count_ff <= load_count_in;
         hold_ff       <= hold_in;
      end
   end

   a_push_holds : assert property (@(posedge clock) disable iff (reset)
      job_valid |=> hold_ff)
      else $error("glyph handed off without holding the store");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CNT_W'(DEPTH))
      else $error("load count beyond store depth");

endmodule

// ===== src/gbbc_back.sv =====
// Crop side: bound scan over the stored raster and emission of cropped words.
module gbbc_back
   import gbbc_pkg::*;
#(
   parameter int MAX_ROWS      = 32,
   parameter int MAX_WORD_COLS = 2,
   localparam int DEPTH  = MAX_ROWS * MAX_WORD_COLS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  job_type                job,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  logic [WORD_W-1:0]      rd_data,
   output logic                   release_hold,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int WC_W = $clog2(MAX_WORD_COLS + 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_FIN    = 6'b000100,
      ST_EMIT_A = 6'b001000,
      ST_EMIT_B = 6'b010000,
      ST_EMIT_C = 6'b100000
   } state_type;

   // Offset (0 = leftmost) of the first and last set bit of a word.
   function automatic logic [3:0] first_pos(input logic [WORD_W-1:0] w);
      logic [3:0] p;
      p = '0;
      for (int i = 15; i >= 0; i--) begin
         if (w[15-i]) p = 4'(i);
      end
      return p;
   endfunction

   function automatic logic [3:0] last_pos(input logic [WORD_W-1:0] w);
      logic [3:0] p;
      p = '0;
      for (int i = 0; i < 16; i++) begin
         if (w[15-i]) p = 4'(i);
      end
      return p;
   endfunction

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   // Scan address generator and the tag of the read in flight.
   logic [DIM_W-1:0]   sc_row_ff, sc_row_in;
   logic [WC_W-1:0]    sc_wcol_ff, sc_wcol_in;
   logic [ADDR_W-1:0]  sc_addr_ff, sc_addr_in;
   logic               tag_valid_ff, tag_valid_in;
   logic [WC_W-1:0]    tag_wcol_ff, tag_wcol_in;
   logic [DIM_W-1:0]   tag_row_ff, tag_row_in;
   // Bounds of the set bits.
   logic               found_ff, found_in;
   logic [DIM_W-1:0]   top_ff, top_in, bottom_ff, bottom_in;
   logic [DIM_W-1:0]   left_ff, left_in, right_ff, right_in;
   // Emission.
   logic [DIM_W-1:0]   e_row_ff, e_row_in;
   logic [WC_W-1:0]    e_k_ff, e_k_in;
   logic [WC_W-1:0]    e_wcol_ff, e_wcol_in;
   logic [ADDR_W-1:0]  e_base_ff, e_base_in;
   logic [WORD_W-1:0]  word0_ff, word0_in;
   logic [DIM_W-1:0]   newrows_ff, newrows_in;
   logic [NCOL_W-1:0]  newcols_ff, newcols_in;
   logic [NW_W-1:0]    newwords_ff, newwords_in;
   logic [3:0]         shift_ff, shift_in;
   logic               extra_ff, extra_in;
   logic [NORG_W-1:0]  orow_ff, orow_in, ocol_ff, ocol_in;
   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               issuing;
   logic [WORD_W-1:0]  scan_mask, word_m, out_mask, word1, out_word;
   logic [DIM_W-1:0]   col_lo, col_hi, row_base;
   logic [6:0]         mcol;
   logic [31:0]        cat;
   logic               second_ok, last_word;
   logic [DIM_W-1:0]   next_row;
   logic [ADDR_W-1:0]  next_base;
   logic [NCOL_W:0]    nw_sum;
   logic [7:0]         base_prod;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign issuing  = (NW_W'(sc_wcol_ff) < job_ff.nwords) && (job_ff.nrows != '0);

   // Scan mask: all padded bits, or only the columns below the box width.
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         mcol = 7'({tag_wcol_ff, 4'b0000}) + 7'(15 - i);
         scan_mask[i] = job_ff.check_all || (mcol < 7'(job_ff.ncols));
      end
      word_m  = rd_data & scan_mask;
      row_base = DIM_W'({tag_wcol_ff, 4'b0000});
      col_lo  = row_base + DIM_W'(first_pos(word_m));
      col_hi  = row_base + DIM_W'(last_pos(word_m));
   end

   // Output word assembly from the two source word columns.
   always_comb begin
      second_ok = (NW_W'(e_wcol_ff) + NW_W'(1)) < job_ff.nwords;
      word1     = second_ok ? rd_data : '0;
      cat       = {word0_ff, word1} << shift_ff;
      for (int i = 0; i < WORD_W; i++) begin
         out_mask[i] = (7'({e_k_ff, 4'b0000}) + 7'(15 - i)) < newcols_ff;
      end
      out_word  = cat[31:16] & out_mask;
      last_word = (e_row_ff == bottom_ff) &&
                  ((NW_W'(e_k_ff) + NW_W'(1)) == newwords_ff);
      next_row  = (e_row_ff == bottom_ff) ? top_ff : e_row_ff + 1'b1;
      next_base = (e_row_ff == bottom_ff) ? e_base_ff + ADDR_W'(job_ff.nrows) :
                                            e_base_ff;
      nw_sum    = (NCOL_W + 1)'(right_ff - left_ff) + (NCOL_W + 1)'(16);
      base_prod = 8'(left_ff[5:4]) * 8'(job_ff.nrows);
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      sc_row_in    = sc_row_ff;
      sc_wcol_in   = sc_wcol_ff;
      sc_addr_in   = sc_addr_ff;
      tag_valid_in = 1'b0;
      tag_wcol_in  = tag_wcol_ff;
      tag_row_in   = tag_row_ff;
      found_in     = found_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      e_row_in     = e_row_ff;
      e_k_in       = e_k_ff;
      e_wcol_in    = e_wcol_ff;
      e_base_in    = e_base_ff;
      word0_in     = word0_ff;
      newrows_in   = newrows_ff;
      newcols_in   = newcols_ff;
      newwords_in  = newwords_ff;
      shift_in     = shift_ff;
      extra_in     = extra_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      job_ready    = 1'b0;
      release_hold = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               job_in     = job;
               sc_row_in  = '0;
               sc_wcol_in = '0;
               sc_addr_in = '0;
               found_in   = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               rd_en        = 1'b1;
               rd_addr      = sc_addr_ff;
               tag_valid_in = 1'b1;
               tag_wcol_in  = sc_wcol_ff;
               tag_row_in   = sc_row_ff;
               sc_addr_in   = sc_addr_ff + 1'b1;
               if (sc_row_ff == job_ff.nrows - 1'b1) begin
                  sc_row_in  = '0;
                  sc_wcol_in = sc_wcol_ff + 1'b1;
               end else begin
                  sc_row_in = sc_row_ff + 1'b1;
               end
            end else if (!tag_valid_ff) begin
               state_in = ST_FIN;
            end
            if (tag_valid_ff && (word_m != '0)) begin
               found_in = 1'b1;
               if (!found_ff) begin
                  top_in    = tag_row_ff;
                  bottom_in = tag_row_ff;
                  left_in   = col_lo;
                  right_in  = col_hi;
               end else begin
                  if (tag_row_ff < top_ff)    top_in    = tag_row_ff;
                  if (tag_row_ff > bottom_ff) bottom_in = tag_row_ff;
                  if (col_lo < left_ff)       left_in   = col_lo;
                  if (col_hi > right_ff)      right_in  = col_hi;
               end
            end
         end
         ST_FIN: begin
            if (!found_ff) begin
               // Empty glyph: a single result carrying only the empty flag.
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_empty_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  release_hold = 1'b1;
                  top_in       = '0;
                  bottom_in    = '0;
                  left_in      = '0;
                  right_in     = '0;
                  state_in     = ST_IDLE;
               end
            end else begin
               newrows_in  = bottom_ff - top_ff + 1'b1;
               newcols_in  = NCOL_W'(right_ff - left_ff) + 1'b1;
               newwords_in = NW_W'(nw_sum >> 4);
               extra_in    = right_ff >= job_ff.ncols;
               orow_in     = {job_ff.origin_row[ORG_W-1], job_ff.origin_row} -
                             NORG_W'(top_ff);
               ocol_in     = {job_ff.origin_col[ORG_W-1], job_ff.origin_col} -
                             NORG_W'(left_ff);
               shift_in    = left_ff[3:0];
               e_row_in    = top_ff;
               e_k_in      = '0;
               e_wcol_in   = WC_W'(left_ff[5:4]);
               e_base_in   = ADDR_W'(base_prod);
               state_in    = ST_EMIT_A;
            end
         end
         ST_EMIT_A: begin
            rd_en    = 1'b1;
            rd_addr  = e_base_ff + ADDR_W'(e_row_ff);
            state_in = ST_EMIT_B;
         end
         ST_EMIT_B: begin
            word0_in = rd_data;
            rd_en    = second_ok;
            rd_addr  = e_base_ff + ADDR_W'(job_ff.nrows) + ADDR_W'(e_row_ff);
            state_in = ST_EMIT_C;
         end
         ST_EMIT_C: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b00000, extra_ff, ocol_ff, orow_ff,
                               newcols_ff[DIM_W-1:0], newrows_ff, out_word};
               rsp_empty_in = 1'b0;
               rsp_last_in  = last_word;
               if (last_word) begin
                  release_hold = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  e_row_in  = next_row;
                  e_base_in = next_base;
                  if (e_row_ff == bottom_ff) begin
                     e_k_in    = e_k_ff + 1'b1;
                     e_wcol_in = e_wcol_ff + 1'b1;
                  end
                  rd_en    = 1'b1;
                  rd_addr  = next_base + ADDR_W'(next_row);
                  state_in = ST_EMIT_B;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tag_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         top_ff       <= '0;
         bottom_ff    <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_valid_ff <= tag_valid_in;
         found_ff     <= found_in;
         top_ff       <= top_in;
         bottom_ff    <= bottom_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      sc_row_ff   <= sc_row_in;
      sc_wcol_ff  <= sc_wcol_in;
      sc_addr_ff  <= sc_addr_in;
      tag_wcol_ff <= tag_wcol_in;
      tag_row_ff  <= tag_row_in;
      e_row_ff    <= e_row_in;
      e_k_ff      <= e_k_in;
      e_wcol_ff   <= e_wcol_in;
      e_base_ff   <= e_base_in;
      word0_ff    <= word0_in;
      newrows_ff  <= newrows_in;
      newcols_ff  <= newcols_in;
      newwords_ff <= newwords_in;
      shift_ff    <= shift_in;
      extra_ff    <= extra_in;
      orow_ff     <= orow_in;
      ocol_ff     <= ocol_in;
      rsp_data_ff <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_release_last : assert property (@(posedge clock) disable iff (reset)
      release_hold |=> rsp_tvalid && rsp_tlast)
      else $error("store released before the final result was loaded");

   a_empty_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("empty glyph result carries data or is not final");

   a_scan_drained : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |-> !tag_valid_ff)
      else $error("bound scan left a read in flight");

endmodule

// ===== src/glyph_bitmap_box_crop.sv =====
// Top level of the glyph bitmap box crop block.
//
//  channel | direction | transfer carries
//  --------+-----------+-------------------------------------------------------
//  csr_    | in        | register index and write data (box size, origin, mode)
//  req_    | in        | one 16-bit raster word; tlast on the glyph's final word
//  rsp_    | out       | one cropped word with new size/origin; tlast on final
//
// Raster words load one per cycle into the store while req_tready is high. The final
// word hands the glyph to the crop side, which scans rows * words_per_row stored
// words at one per cycle, then emits each cropped word once its source words have
// been read in turn through the single read port of the store. An empty glyph gives
// one result right after the scan. While a glyph is being cropped the req_ side is
// held off, since the store still holds its raster. The result register lets the
// crop side finish a word while the previous one waits on rsp_tready. Reset is
// synchronous; it returns the control and configuration registers, not the data
// registers, to their defaults (check_all_bits = 1) and leaves the raster store as it was.
module glyph_bitmap_box_crop
   import gbbc_pkg::*;
#(
   parameter int MAX_ROWS      = 32,
   parameter int MAX_WORD_COLS = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   // Raster word input.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [WORD_W-1:0]      req_tdata,   // [15:0] raster_word
   input  logic                   req_tlast,   // last_word
   // Cropped result output.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] out_word, [21:16] new_rows, [27:22] new_cols,
   // [38:28] new_origin_row, [49:39] new_origin_col, [50] extra_bits, [55:51] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,   // [0] glyph_empty
   output logic                   rsp_tlast    // last_out
);

   localparam int DEPTH  = MAX_ROWS * MAX_WORD_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Store write port, driven by the load side.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   // Store read port, driven by the crop side.
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   // Job queue between the two sides.
   logic              push_valid, push_ready;
   job_type           push_job;
   logic              pop_valid, pop_ready;
   job_type           pop_job;
   // The crop side frees the store once its final read has been used.
   logic              release_hold;

   gbbc_front #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_WORD_COLS (MAX_WORD_COLS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .job_valid    (push_valid),
      .job_ready    (push_ready),
      .job          (push_job),
      .release_hold (release_hold)
   );

   gbbc_job_fifo #(
      .DEPTH (2)
   ) u_job_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   gbbc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gbbc_back #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_WORD_COLS (MAX_WORD_COLS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (pop_valid),
      .job_ready    (pop_ready),
      .job          (pop_job),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .release_hold (release_hold),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
